@@ sv/absrv_pkg.sv @@
// ----------------------------------------------------------------------------
// absrv_pkg: shared types and constants for the A/B slot record validator
// Field structs, status codes and CRC-32 byte step.
// ----------------------------------------------------------------------------
package absrv_pkg;

  localparam int unsigned HEADER_BYTES   = 64;
  localparam int unsigned MAX_SLOT_BYTES = 4096;
  localparam int unsigned POS_W          = $clog2(MAX_SLOT_BYTES + 1);

  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL   = 32'hFFFF_FFFF;
  localparam logic [7:0]  BYTE_ONES = 8'hFF;

  localparam logic [2:0] ST_VALID   = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_BAD_VER = 3'd2;
  localparam logic [2:0] ST_LEN_OVF = 3'd3;
  localparam logic [2:0] ST_BAD_CRC = 3'd4;
  localparam logic [2:0] ST_SHORT   = 3'd5;

  localparam logic [1:0] LATEST_NONE = 2'd0;
  localparam logic [1:0] LATEST_A    = 2'd1;
  localparam logic [1:0] LATEST_B    = 2'd2;

  localparam logic [2:0] CFG_MAGIC   = 3'd0;
  localparam logic [2:0] CFG_VERSION = 3'd1;
  localparam logic [2:0] CFG_SCH_MIN = 3'd2;
  localparam logic [2:0] CFG_SCH_MAX = 3'd3;
  localparam logic [2:0] CFG_PTYPE   = 3'd4;

  // result queue: power-of-two depth, pointers wrap
  localparam int unsigned OUT_QD = 4;
  localparam int unsigned OUT_AW = $clog2(OUT_QD);
  localparam logic [OUT_AW-1:0] OUT_PTR_ONE    = OUT_AW'(1);
  localparam logic [OUT_AW:0]   OUT_ROOM_LIMIT = (OUT_AW + 1)'(OUT_QD - 2);

  typedef struct packed {
    logic       slot_select;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] payload_length;
    logic [63:0] record_counter;
    logic [1:0]  newest_slot;
    logic [63:0] latest_counter;
    logic        write_slot;
    logic [63:0] upcoming_counter;
  } out_item_t;

  // classified slot summary passed from scanner to slot tracker
  typedef struct packed {
    logic        slot_select;
    logic [2:0]  status;
    logic [31:0] payload_length;
    logic [63:0] record_counter;
  } verdict_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/absrv_scan.sv @@
// ----------------------------------------------------------------------------
// absrv_scan: byte scanner
// Captures header fields, runs the payload CRC and classifies the slot.
// ----------------------------------------------------------------------------
module absrv_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  absrv_pkg::in_item_t in_item,
  input  logic [31:0]         exp_magic,
  input  logic [15:0]         exp_version,
  input  logic [15:0]         schema_min,
  input  logic [15:0]         schema_max,
  input  logic [15:0]         exp_ptype,
  output logic                vd_valid,
  output absrv_pkg::verdict_t vd
);

  localparam int unsigned PW = absrv_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic          zero_r, zero_nxt, ones_r, ones_nxt;
  logic [31:0]   magic_r, magic_nxt, len_r, len_nxt, hcrc_r, hcrc_nxt;
  logic [15:0]   ver_r, ver_nxt, sch_r, sch_nxt, typ_r, typ_nxt;
  logic [63:0]   cnt_r, cnt_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic          vd_valid_nxt;
  absrv_pkg::verdict_t vd_nxt;

  logic [7:0] b;
  logic       take_b;
  logic [32:0] pay_end;
  logic [31:0] avail;

  assign b = in_item.data_byte;

  always_comb begin
    take_b    = in_take && (pos_r < PW'(absrv_pkg::MAX_SLOT_BYTES));
    pos_nxt   = pos_r;
    zero_nxt  = zero_r;
    ones_nxt  = ones_r;
    magic_nxt = magic_r;
    ver_nxt   = ver_r;
    sch_nxt   = sch_r;
    typ_nxt   = typ_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    hcrc_nxt  = hcrc_r;
    crc_nxt   = crc_r;
    pay_end   = 33'(absrv_pkg::HEADER_BYTES) + {1'b0, len_r};
    if (take_b) begin
      if (b != 8'd0) zero_nxt = 1'b0;
      if (b != absrv_pkg::BYTE_ONES) ones_nxt = 1'b0;
      if (pos_r < PW'(4)) magic_nxt[8*pos_r[1:0] +: 8] = b;
      else if (pos_r < PW'(6)) ver_nxt[8*pos_r[0] +: 8] = b;
      else if (pos_r < PW'(8)) sch_nxt[8*pos_r[0] +: 8] = b;
      else if (pos_r < PW'(10)) typ_nxt[8*pos_r[0] +: 8] = b;
      else if (pos_r >= PW'(12) && pos_r < PW'(16)) len_nxt[8*pos_r[1:0] +: 8] = b;
      else if (pos_r >= PW'(16) && pos_r < PW'(24)) cnt_nxt[8*pos_r[2:0] +: 8] = b;
      else if (pos_r >= PW'(32) && pos_r < PW'(36)) hcrc_nxt[8*pos_r[1:0] +: 8] = b;
      if (pos_r >= PW'(absrv_pkg::HEADER_BYTES) && 33'(pos_r) < pay_end)
        crc_nxt = absrv_pkg::crc_byte(crc_r, b);
      pos_nxt = pos_r + PW'(1);
    end

    avail        = 32'(pos_nxt) - 32'(absrv_pkg::HEADER_BYTES);
    vd_valid_nxt = in_take && in_item.last_byte;
    vd_nxt.slot_select    = in_item.slot_select;
    vd_nxt.payload_length = len_nxt;
    vd_nxt.record_counter = cnt_nxt;
    if (pos_nxt < PW'(absrv_pkg::HEADER_BYTES)) begin
      vd_nxt.status         = absrv_pkg::ST_SHORT;
      vd_nxt.payload_length = '0;
      vd_nxt.record_counter = '0;
    end else if (zero_nxt || ones_nxt)
      vd_nxt.status = absrv_pkg::ST_EMPTY;
    else if (magic_nxt != exp_magic || ver_nxt != exp_version || sch_nxt < schema_min ||
             sch_nxt > schema_max || typ_nxt != exp_ptype)
      vd_nxt.status = absrv_pkg::ST_BAD_VER;
    else if (len_nxt > avail)
      vd_nxt.status = absrv_pkg::ST_LEN_OVF;
    else if ((crc_nxt ^ absrv_pkg::CRC_ALL) != hcrc_nxt)
      vd_nxt.status = absrv_pkg::ST_BAD_CRC;
    else
      vd_nxt.status = absrv_pkg::ST_VALID;

    // slot ends: scan state back to reset
    if (vd_valid_nxt) begin
      pos_nxt   = '0;
      zero_nxt  = 1'b1;
      ones_nxt  = 1'b1;
      magic_nxt = '0;
      ver_nxt   = '0;
      sch_nxt   = '0;
      typ_nxt   = '0;
      len_nxt   = '0;
      cnt_nxt   = '0;
      hcrc_nxt  = '0;
      crc_nxt   = absrv_pkg::CRC_ALL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      zero_r   <= 1'b1;
      ones_r   <= 1'b1;
      magic_r  <= '0;
      ver_r    <= '0;
      sch_r    <= '0;
      typ_r    <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      hcrc_r   <= '0;
      crc_r    <= absrv_pkg::CRC_ALL;
      vd_valid <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      zero_r   <= zero_nxt;
      ones_r   <= ones_nxt;
      magic_r  <= magic_nxt;
      ver_r    <= ver_nxt;
      sch_r    <= sch_nxt;
      typ_r    <= typ_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      hcrc_r   <= hcrc_nxt;
      crc_r    <= crc_nxt;
      vd_valid <= vd_valid_nxt;
    end
    vd <= vd_nxt;
  end

endmodule

@@ sv/absrv_track.sv @@
// ----------------------------------------------------------------------------
// absrv_track: slot tracker and result queue
// Records per-slot validity, picks the latest slot and buffers results.
// ----------------------------------------------------------------------------
module absrv_track (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vd_valid,
  input  absrv_pkg::verdict_t  vd,
  output logic                 q_room,
  output logic                 out_empty,
  input  logic                 out_pop,
  output absrv_pkg::out_item_t out_item
);

  logic [1:0]  valid_r, valid_nxt;
  logic [63:0] cnt_r [2];
  logic [63:0] cnt_nxt [2];
  logic [1:0]  latest;
  logic [63:0] lcnt;
  absrv_pkg::out_item_t res;

  // two verdicts may be in flight when full is raised
  absrv_pkg::out_item_t q_r [absrv_pkg::OUT_QD];
  logic [absrv_pkg::OUT_AW-1:0] wp_r, rp_r;
  logic [absrv_pkg::OUT_AW:0]   fill_r;
  logic [absrv_pkg::OUT_AW:0]   push_ext, pop_ext;
  logic       push_q, pop_q;

  always_comb begin
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    if (vd_valid) begin
      valid_nxt[vd.slot_select] = (vd.status == absrv_pkg::ST_VALID);
      cnt_nxt[vd.slot_select]   = (vd.status == absrv_pkg::ST_VALID) ? vd.record_counter : '0;
    end
    if (valid_nxt[0] && valid_nxt[1])
      latest = (cnt_nxt[1] > cnt_nxt[0]) ? absrv_pkg::LATEST_B : absrv_pkg::LATEST_A;
    else if (valid_nxt[0]) latest = absrv_pkg::LATEST_A;
    else if (valid_nxt[1]) latest = absrv_pkg::LATEST_B;
    else latest = absrv_pkg::LATEST_NONE;
    case (latest)
      absrv_pkg::LATEST_A: lcnt = cnt_nxt[0];
      absrv_pkg::LATEST_B: lcnt = cnt_nxt[1];
      default:             lcnt = '0;
    endcase
    res.status           = vd.status;
    res.payload_length   = vd.payload_length;
    res.record_counter   = vd.record_counter;
    res.newest_slot      = latest;
    res.latest_counter   = lcnt;
    res.write_slot       = (latest == absrv_pkg::LATEST_A);
    res.upcoming_counter = (latest == absrv_pkg::LATEST_NONE) ? 64'd1 : lcnt + 64'd1;
  end

  assign push_q    = vd_valid;
  assign out_empty = (fill_r == '0);
  assign pop_q     = out_pop && !out_empty;
  assign push_ext  = {{absrv_pkg::OUT_AW{1'b0}}, push_q};
  assign pop_ext   = {{absrv_pkg::OUT_AW{1'b0}}, pop_q};
  assign out_item  = q_r[rp_r];
  assign q_room    = (fill_r + push_ext) <= absrv_pkg::OUT_ROOM_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      wp_r    <= '0;
      rp_r    <= '0;
      fill_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      if (push_q) wp_r <= wp_r + absrv_pkg::OUT_PTR_ONE;
      if (pop_q) rp_r <= rp_r + absrv_pkg::OUT_PTR_ONE;
      fill_r <= fill_r + push_ext - pop_ext;
    end
    if (push_q) q_r[wp_r] <= res;
  end

endmodule

@@ sv/ab_slot_record_validator.sv @@
// ----------------------------------------------------------------------------
// ab_slot_record_validator: A/B storage slot record check
// Streams slot bytes, checks header and payload CRC-32, tracks latest slot.
// ----------------------------------------------------------------------------
// One byte per cycle is accepted back to back while in_full is low. The
// scanner captures the header and updates the CRC in the cycle a byte is
// taken; on the last byte a verdict is registered, and in the following
// cycle the slot tracker writes the result into a four-entry output queue.
// full rises only when the queue cannot absorb the results in flight,
// i.e. when the results waiting unread plus the one being written reach three.
module ab_slot_record_validator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  absrv_pkg::in_item_t  in_item,
  output logic                 out_empty,
  input  logic                 out_pop,
  output absrv_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] magic_r;
  logic [15:0] ver_r, smin_r, smax_r, ptype_r;
  logic        in_take, q_room, vd_valid, vd_valid_q;
  absrv_pkg::verdict_t vd;

  assign cfg_ready = 1'b1;
  // full leaves room for the registered verdict and the byte being taken
  assign in_full = !q_room;
  assign in_take = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r <= '0;
      ver_r   <= '0;
      smin_r  <= '0;
      smax_r  <= '0;
      ptype_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        absrv_pkg::CFG_MAGIC:   magic_r <= cfg_data;
        absrv_pkg::CFG_VERSION: ver_r   <= cfg_data[15:0];
        absrv_pkg::CFG_SCH_MIN: smin_r  <= cfg_data[15:0];
        absrv_pkg::CFG_SCH_MAX: smax_r  <= cfg_data[15:0];
        absrv_pkg::CFG_PTYPE:   ptype_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign vd_valid_q = vd_valid;

  absrv_scan u_scan (
    .clk(clk), .rst_n(rst_n), .in_take(in_take), .in_item(in_item),
    .exp_magic(magic_r), .exp_version(ver_r), .schema_min(smin_r),
    .schema_max(smax_r), .exp_ptype(ptype_r), .vd_valid(vd_valid), .vd(vd)
  );

  absrv_track u_track (
    .clk(clk), .rst_n(rst_n), .vd_valid(vd_valid_q), .vd(vd), .q_room(q_room),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

endmodule
